/* rtl/pairwise_haplotype_jaccard_top_macros.svh */
// Assertion macros shared by the pairwise haplotype Jaccard RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef PAIRWISE_HAPLOTYPE_JACCARD_TOP_MACROS_SVH
`define PAIRWISE_HAPLOTYPE_JACCARD_TOP_MACROS_SVH

// Check a property on every clock edge outside reset
`define PHJ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define PHJ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/phj_pkg.sv */
// Types and constants of the pairwise haplotype Jaccard block.
// Used by every module of the block; depends on nothing.
package phj_pkg;

    localparam int MAX_SAMPLES = 256;
    localparam int MAX_HAPS    = 1024;
    localparam int MAX_TARGETS = 128;

    localparam int SAMPLE_W   = 8;
    localparam int HAP_IDX_W  = 10;
    localparam int TGT_IDX_W  = 7;
    localparam int HAP_ADDR_W = SAMPLE_W + HAP_IDX_W;
    localparam int TGT_ADDR_W = SAMPLE_W + TGT_IDX_W;
    localparam int LAYOUT_W   = 21;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;

    localparam int DIV_NUM_W = 44;
    localparam int DIV_DEN_W = 27;
    localparam int DIV_Q_W   = 17;
    localparam int DIV_CNT_W = 6;

    // Command codes of the input channel
    localparam logic [2:0] CMD_HAP    = 3'd0;
    localparam logic [2:0] CMD_TGT    = 3'd1;
    localparam logic [2:0] CMD_LAYOUT = 3'd2;
    localparam logic [2:0] CMD_FREQ   = 3'd3;
    localparam logic [2:0] CMD_CMP    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_TARGET_TOTAL    = 2'd0;
    localparam logic [1:0] REG_HAPLOTYPE_TOTAL = 2'd1;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] WEIGHT_BASE = 17'd66191;
    localparam logic [10:0] CNT11_MAX   = 11'h7FF;
    localparam logic [26:0] SUM27_MAX   = 27'h7FF_FFFF;

    typedef enum logic [2:0] {
        OP_HAP,
        OP_TGT,
        OP_LAYOUT,
        OP_FREQ,
        OP_CMP,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  sample_a;
        logic [7:0]  sample_b;
        logic [9:0]  position;
        logic        bit_value;
        logic [9:0]  layout_start;
        logic [10:0] layout_count;
        logic [16:0] frequency;
    } item_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [10:0] shared_common;
        logic [10:0] union_common;
        logic [26:0] weighted_shared;
        logic [26:0] weighted_union;
        logic [7:0]  targets_both;
        logic [7:0]  targets_sharing;
        logic [16:0] mean_jaccard;
        logic [16:0] mean_weighted_jaccard;
        logic [10:0] shared_all;
        logic [10:0] union_all;
    } result_t;

endpackage

/* rtl/phj_front.sv */
// Front end: accepts input transfers, classifies them and queues them.
// Depends on phj_pkg.
module phj_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [2:0]     cmd,
    input  logic [7:0]     sample_a,
    input  logic [7:0]     sample_b,
    input  logic [9:0]     position,
    input  logic           bit_value,
    input  logic [9:0]     layout_start,
    input  logic [10:0]    layout_count,
    input  logic [16:0]    frequency,
    input  logic           clearing,
    output phj_pkg::item_t head,
    output logic           head_valid,
    input  logic           pop
);

    phj_pkg::item_t                   fifo_mem [phj_pkg::FIFO_DEPTH];
    logic [phj_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [phj_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [phj_pkg::FIFO_PTR_W:0]     count_reg;
    logic [phj_pkg::FIFO_PTR_W:0]     count_next;
    phj_pkg::item_t                   item;
    logic                             push;
    logic                             do_pop;

    // Classify: range-check loads, saturate frequency, drop unused codes
    always_comb
    begin
        item.sample_a     = sample_a;
        item.sample_b     = sample_b;
        item.position     = position;
        item.bit_value    = bit_value;
        item.layout_start = layout_start;
        item.layout_count = layout_count;
        item.frequency    = (frequency > phj_pkg::ONE_Q16) ? phj_pkg::ONE_Q16 : frequency;
        case (cmd)
            phj_pkg::CMD_HAP:
                item.op = ({1'b0, position} < 11'(phj_pkg::MAX_HAPS)) ?
                          phj_pkg::OP_HAP : phj_pkg::OP_NONE;
            phj_pkg::CMD_TGT:
                item.op = ({1'b0, position} < 11'(phj_pkg::MAX_TARGETS)) ?
                          phj_pkg::OP_TGT : phj_pkg::OP_NONE;
            phj_pkg::CMD_LAYOUT:
                item.op = ({1'b0, position} < 11'(phj_pkg::MAX_TARGETS)) ?
                          phj_pkg::OP_LAYOUT : phj_pkg::OP_NONE;
            phj_pkg::CMD_FREQ:
                item.op = ({1'b0, position} < 11'(phj_pkg::MAX_HAPS)) ?
                          phj_pkg::OP_FREQ : phj_pkg::OP_NONE;
            phj_pkg::CMD_CMP:
                item.op = phj_pkg::OP_CMP;
            default:
                item.op = phj_pkg::OP_NONE;
        endcase
    end

    assign in_stall   = (count_reg == (phj_pkg::FIFO_PTR_W+1)'(phj_pkg::FIFO_DEPTH)) || clearing;
    assign push       = in_valid && !in_stall && (item.op != phj_pkg::OP_NONE);
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Hold queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= item;
        end
    end

endmodule

/* rtl/phj_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on phj_pkg. A zero divisor gives a quotient of zero.
module phj_div (
    input  logic              clk,
    input  logic              rst_n,
    input  phj_pkg::div_req_t req,
    output phj_pkg::div_rsp_t rsp
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [phj_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic [phj_pkg::DIV_DEN_W-1:0]   rem_reg;
    logic [phj_pkg::DIV_DEN_W-1:0]   den_reg;
    logic [phj_pkg::DIV_NUM_W-1:0]   dvd_reg;
    logic [phj_pkg::DIV_NUM_W-1:0]   quot_reg;
    logic [phj_pkg::DIV_DEN_W:0]     trial;
    logic                            ge;

    assign trial = {rem_reg, dvd_reg[phj_pkg::DIV_NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = (den_reg == '0) ? '0 : quot_reg[phj_pkg::DIV_Q_W-1:0];

    // Control: count steps, pulse done at the end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= phj_pkg::DIV_CNT_W'(phj_pkg::DIV_NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == phj_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift in one dividend bit, subtract where it fits
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dvd_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? phj_pkg::DIV_DEN_W'(trial - {1'b0, den_reg})
                           : trial[phj_pkg::DIV_DEN_W-1:0];
            quot_reg <= {quot_reg[phj_pkg::DIV_NUM_W-2:0], ge};
            dvd_reg  <= {dvd_reg[phj_pkg::DIV_NUM_W-2:0], 1'b0};
        end
    end

endmodule

/* rtl/phj_back.sv */
// Back end: holds the presence, layout and frequency memories, carries out
// loads and walks compares. Depends on phj_pkg and the assertion macros.
`include "pairwise_haplotype_jaccard_top_macros.svh"

module phj_back (
    input  logic              clk,
    input  logic              rst_n,
    input  phj_pkg::item_t    head,
    input  logic              head_valid,
    output logic              pop,
    output logic              clearing,
    input  logic [7:0]        target_total,
    input  logic [10:0]       haplotype_total,
    output phj_pkg::div_req_t div_req,
    input  phj_pkg::div_rsp_t div_rsp,
    input  logic              res_ready,
    output logic              res_valid,
    output phj_pkg::result_t  res
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_T_ISSUE,
        S_T_CHECK,
        S_P_ISSUE,
        S_P_ACC,
        S_J_START,
        S_J_WAIT,
        S_W_START,
        S_W_WAIT,
        S_H_ISSUE,
        S_H_ACC,
        S_MJ_START,
        S_MJ_WAIT,
        S_MW_START,
        S_MW_WAIT,
        S_DONE
    } state_t;

    // Memories
    logic                           hap_mem  [2**phj_pkg::HAP_ADDR_W];
    logic                           tgt_mem  [2**phj_pkg::TGT_ADDR_W];
    logic [phj_pkg::LAYOUT_W-1:0]   lay_mem  [phj_pkg::MAX_TARGETS];
    logic [16:0]                    freq_mem [phj_pkg::MAX_HAPS];

    logic                           hap_we;
    logic [phj_pkg::HAP_ADDR_W-1:0] hap_waddr;
    logic                           hap_wdata;
    logic                           tgt_we;
    logic [phj_pkg::TGT_ADDR_W-1:0] tgt_waddr;
    logic                           tgt_wdata;
    logic                           lay_we;
    logic                           freq_we;

    logic                           hap_rd_a;
    logic                           hap_rd_b;
    logic                           tgt_rd_a;
    logic                           tgt_rd_b;
    logic [phj_pkg::LAYOUT_W-1:0]   lay_rd;
    logic [16:0]                    freq_rd;

    state_t                         state_reg, state_next;
    logic [phj_pkg::HAP_ADDR_W-1:0] clr_reg, clr_next;
    logic [7:0]   sa_reg, sa_next, sb_reg, sb_next;
    logic [7:0]   t_reg, t_next;
    logic [10:0]  p_reg, p_next, end_reg, end_next;
    logic [10:0]  tsh_reg, tsh_next, tun_reg, tun_next;
    logic [26:0]  twsh_reg, twsh_next, twun_reg, twun_next;
    logic [10:0]  sh_reg, sh_next, un_reg, un_next;
    logic [26:0]  wsh_reg, wsh_next, wun_reg, wun_next;
    logic [7:0]   both_reg, both_next, sharing_reg, sharing_next;
    logic [23:0]  jsum_reg, jsum_next, wjsum_reg, wjsum_next;
    logic [10:0]  shall_reg, shall_next, unall_reg, unall_next;
    logic [16:0]  mj_reg, mj_next, mwj_reg, mwj_next;

    logic [7:0]   ntar;
    logic [10:0]  nhap;
    logic [11:0]  end_full;
    logic [16:0]  weight;
    logic [11:0]  sh_sum, un_sum;
    logic [27:0]  wsh_sum, wun_sum;

    // Clamp the registers to the table depths
    assign ntar = (target_total > 8'(phj_pkg::MAX_TARGETS)) ?
                  8'(phj_pkg::MAX_TARGETS) : target_total;
    assign nhap = (haplotype_total > 11'(phj_pkg::MAX_HAPS)) ?
                  11'(phj_pkg::MAX_HAPS) : haplotype_total;

    assign end_full = {2'b00, lay_rd[phj_pkg::LAYOUT_W-1:11]} + {1'b0, lay_rd[10:0]};
    assign weight   = phj_pkg::WEIGHT_BASE - freq_rd;
    assign sh_sum   = {1'b0, sh_reg} + {1'b0, tsh_reg};
    assign un_sum   = {1'b0, un_reg} + {1'b0, tun_reg};
    assign wsh_sum  = {1'b0, wsh_reg} + {1'b0, twsh_reg};
    assign wun_sum  = {1'b0, wun_reg} + {1'b0, twun_reg};

    assign clearing  = (state_reg == S_CLEAR);
    assign res_valid = (state_reg == S_DONE) && res_ready;

    assign res.shared_common         = sh_reg;
    assign res.union_common          = un_reg;
    assign res.weighted_shared       = wsh_reg;
    assign res.weighted_union        = wun_reg;
    assign res.targets_both          = both_reg;
    assign res.targets_sharing       = sharing_reg;
    assign res.mean_jaccard          = mj_reg;
    assign res.mean_weighted_jaccard = mwj_reg;
    assign res.shared_all            = shall_reg;
    assign res.union_all             = unall_reg;

    // Next-state and datapath
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        t_next       = t_reg;
        p_next       = p_reg;
        end_next     = end_reg;
        tsh_next     = tsh_reg;
        tun_next     = tun_reg;
        twsh_next    = twsh_reg;
        twun_next    = twun_reg;
        sh_next      = sh_reg;
        un_next      = un_reg;
        wsh_next     = wsh_reg;
        wun_next     = wun_reg;
        both_next    = both_reg;
        sharing_next = sharing_reg;
        jsum_next    = jsum_reg;
        wjsum_next   = wjsum_reg;
        shall_next   = shall_reg;
        unall_next   = unall_reg;
        mj_next      = mj_reg;
        mwj_next     = mwj_reg;

        pop       = 1'b0;
        hap_we    = 1'b0;
        hap_waddr = {head.sample_a, head.position};
        hap_wdata = head.bit_value;
        tgt_we    = 1'b0;
        tgt_waddr = {head.sample_a, head.position[phj_pkg::TGT_IDX_W-1:0]};
        tgt_wdata = head.bit_value;
        lay_we    = 1'b0;
        freq_we   = 1'b0;

        div_req.start = 1'b0;
        div_req.num   = {6'b0, tsh_reg, 27'b0} >> 11;
        div_req.den   = {16'b0, tun_reg};

        case (state_reg)
            S_CLEAR:
            begin
                // Sweep zeros through both presence memories
                hap_we    = 1'b1;
                hap_waddr = clr_reg;
                hap_wdata = 1'b0;
                tgt_we    = 1'b1;
                tgt_waddr = clr_reg[phj_pkg::TGT_ADDR_W-1:0];
                tgt_wdata = 1'b0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (head_valid)
                begin
                    pop = 1'b1;
                    case (head.op)
                        phj_pkg::OP_HAP:    hap_we  = 1'b1;
                        phj_pkg::OP_TGT:    tgt_we  = 1'b1;
                        phj_pkg::OP_LAYOUT: lay_we  = 1'b1;
                        phj_pkg::OP_FREQ:   freq_we = 1'b1;
                        phj_pkg::OP_CMP:
                        begin
                            sa_next      = head.sample_a;
                            sb_next      = head.sample_b;
                            t_next       = '0;
                            sh_next      = '0;
                            un_next      = '0;
                            wsh_next     = '0;
                            wun_next     = '0;
                            both_next    = '0;
                            sharing_next = '0;
                            jsum_next    = '0;
                            wjsum_next   = '0;
                            shall_next   = '0;
                            unall_next   = '0;
                            state_next   = S_T_ISSUE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_T_ISSUE:
            begin
                if (t_reg >= ntar)
                begin
                    p_next     = '0;
                    state_next = S_H_ISSUE;
                end
                else
                begin
                    state_next = S_T_CHECK;
                end
            end
            S_T_CHECK:
            begin
                // Enter the target only when both samples hold it
                if (tgt_rd_a && tgt_rd_b)
                begin
                    both_next  = both_reg + 1'b1;
                    tsh_next   = '0;
                    tun_next   = '0;
                    twsh_next  = '0;
                    twun_next  = '0;
                    p_next     = {1'b0, lay_rd[phj_pkg::LAYOUT_W-1:11]};
                    end_next   = (end_full > {1'b0, nhap}) ? nhap : end_full[10:0];
                    state_next = S_P_ISSUE;
                end
                else
                begin
                    t_next     = t_reg + 1'b1;
                    state_next = S_T_ISSUE;
                end
            end
            S_P_ISSUE:
            begin
                state_next = (p_reg >= end_reg) ? S_J_START : S_P_ACC;
            end
            S_P_ACC:
            begin
                if (hap_rd_a && hap_rd_b)
                begin
                    tsh_next  = tsh_reg + 1'b1;
                    twsh_next = twsh_reg + {10'b0, weight};
                end
                if (hap_rd_a || hap_rd_b)
                begin
                    tun_next  = tun_reg + 1'b1;
                    twun_next = twun_reg + {10'b0, weight};
                end
                p_next     = p_reg + 1'b1;
                state_next = S_P_ISSUE;
            end
            S_J_START:
            begin
                div_req.start = 1'b1;
                state_next    = S_J_WAIT;
            end
            S_J_WAIT:
            begin
                if (div_rsp.done)
                begin
                    jsum_next  = jsum_reg + {7'b0, div_rsp.quot};
                    state_next = S_W_START;
                end
            end
            S_W_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = {1'b0, twsh_reg, 16'b0};
                div_req.den   = twun_reg;
                state_next    = S_W_WAIT;
            end
            S_W_WAIT:
            begin
                if (div_rsp.done)
                begin
                    // Fold the target into the saturating totals
                    wjsum_next   = wjsum_reg + {7'b0, div_rsp.quot};
                    sh_next      = sh_sum[11] ? phj_pkg::CNT11_MAX : sh_sum[10:0];
                    un_next      = un_sum[11] ? phj_pkg::CNT11_MAX : un_sum[10:0];
                    wsh_next     = wsh_sum[27] ? phj_pkg::SUM27_MAX : wsh_sum[26:0];
                    wun_next     = wun_sum[27] ? phj_pkg::SUM27_MAX : wun_sum[26:0];
                    sharing_next = sharing_reg + {7'b0, (tsh_reg != '0)};
                    t_next       = t_reg + 1'b1;
                    state_next   = S_T_ISSUE;
                end
            end
            S_H_ISSUE:
            begin
                state_next = (p_reg >= nhap) ? S_MJ_START : S_H_ACC;
            end
            S_H_ACC:
            begin
                if (hap_rd_a && hap_rd_b)
                begin
                    shall_next = shall_reg + 1'b1;
                end
                if (hap_rd_a || hap_rd_b)
                begin
                    unall_next = unall_reg + 1'b1;
                end
                p_next     = p_reg + 1'b1;
                state_next = S_H_ISSUE;
            end
            S_MJ_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = {20'b0, jsum_reg};
                div_req.den   = {19'b0, both_reg};
                state_next    = S_MJ_WAIT;
            end
            S_MJ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mj_next    = div_rsp.quot;
                    state_next = S_MW_START;
                end
            end
            S_MW_START:
            begin
                div_req.start = 1'b1;
                div_req.num   = {20'b0, wjsum_reg};
                div_req.den   = {19'b0, both_reg};
                state_next    = S_MW_WAIT;
            end
            S_MW_WAIT:
            begin
                if (div_rsp.done)
                begin
                    mwj_next   = div_rsp.quot;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sa_reg      <= sa_next;
        sb_reg      <= sb_next;
        t_reg       <= t_next;
        p_reg       <= p_next;
        end_reg     <= end_next;
        tsh_reg     <= tsh_next;
        tun_reg     <= tun_next;
        twsh_reg    <= twsh_next;
        twun_reg    <= twun_next;
        sh_reg      <= sh_next;
        un_reg      <= un_next;
        wsh_reg     <= wsh_next;
        wun_reg     <= wun_next;
        both_reg    <= both_next;
        sharing_reg <= sharing_next;
        jsum_reg    <= jsum_next;
        wjsum_reg   <= wjsum_next;
        shall_reg   <= shall_next;
        unall_reg   <= unall_next;
        mj_reg      <= mj_next;
        mwj_reg     <= mwj_next;
    end

    // Presence memories: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (hap_we)
        begin
            hap_mem[hap_waddr] <= hap_wdata;
        end
        hap_rd_a <= hap_mem[{sa_reg, p_reg[phj_pkg::HAP_IDX_W-1:0]}];
        hap_rd_b <= hap_mem[{sb_reg, p_reg[phj_pkg::HAP_IDX_W-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        tgt_rd_a <= tgt_mem[{sa_reg, t_reg[phj_pkg::TGT_IDX_W-1:0]}];
        tgt_rd_b <= tgt_mem[{sb_reg, t_reg[phj_pkg::TGT_IDX_W-1:0]}];
    end

    // Layout and frequency tables
    always_ff @(posedge clk)
    begin
        if (lay_we)
        begin
            lay_mem[head.position[phj_pkg::TGT_IDX_W-1:0]] <=
                {head.layout_start, head.layout_count};
        end
        lay_rd <= lay_mem[t_reg[phj_pkg::TGT_IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (freq_we)
        begin
            freq_mem[head.position] <= head.frequency;
        end
        freq_rd <= freq_mem[p_reg[phj_pkg::HAP_IDX_W-1:0]];
    end

    `PHJ_ASSERT(a_div_start_idle, div_req.start |-> !div_rsp.busy, "divider started while busy")
    `PHJ_ASSERT(a_pop_has_head, pop |-> head_valid, "pop from an empty queue")
    `PHJ_ASSERT(a_result_ready, res_valid |-> res_ready, "result offered while output full")
    `PHJ_ASSERT_ALWAYS(a_no_pop_clear, clearing |-> !pop, "queue popped during clearing")

endmodule

/* rtl/pairwise_haplotype_jaccard_top.sv */
// Top level of the pairwise haplotype Jaccard block: configuration
// registers, output register. Depends on phj_pkg, phj_front, phj_div, phj_back.
//
// After reset the block runs a clearing pass over every address of the
// presence memories, with input stalled; configuration writes are taken
// throughout. The back end carries out each load as it pops it. A compare
// walks the targets in use, the haplotypes of each target that both
// samples hold, and then the haplotype positions in use, before the output
// register is loaded: presence bits are read from one registered port per
// sample, with an issue state and an accumulate state for each position,
// and each ratio goes through one shared divider that yields one bit per
// cycle.
module pairwise_haplotype_jaccard_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [7:0]  sample_a,
    input  logic [7:0]  sample_b,
    input  logic [9:0]  position,
    input  logic        bit_value,
    input  logic [9:0]  layout_start,
    input  logic [10:0] layout_count,
    input  logic [16:0] frequency,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] shared_common,
    output logic [10:0] union_common,
    output logic [26:0] weighted_shared,
    output logic [26:0] weighted_union,
    output logic [7:0]  targets_both,
    output logic [7:0]  targets_sharing,
    output logic [16:0] mean_jaccard,
    output logic [16:0] mean_weighted_jaccard,
    output logic [10:0] shared_all,
    output logic [10:0] union_all
);

    logic [7:0]        target_total_reg;
    logic [10:0]       haplotype_total_reg;
    logic              out_valid_reg;
    phj_pkg::result_t  out_reg;

    phj_pkg::item_t    head;
    logic              head_valid;
    logic              pop;
    logic              clearing;
    phj_pkg::div_req_t div_req;
    phj_pkg::div_rsp_t div_rsp;
    logic              res_ready;
    logic              res_valid;
    phj_pkg::result_t  res;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_total_reg    <= '0;
            haplotype_total_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                phj_pkg::REG_TARGET_TOTAL:    target_total_reg    <= cfg_data[7:0];
                phj_pkg::REG_HAPLOTYPE_TOTAL: haplotype_total_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    phj_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .sample_a     (sample_a),
        .sample_b     (sample_b),
        .position     (position),
        .bit_value    (bit_value),
        .layout_start (layout_start),
        .layout_count (layout_count),
        .frequency    (frequency),
        .clearing     (clearing),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop)
    );

    phj_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    phj_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop),
        .clearing        (clearing),
        .target_total    (target_total_reg),
        .haplotype_total (haplotype_total_reg),
        .div_req         (div_req),
        .div_rsp         (div_rsp),
        .res_ready       (res_ready),
        .res_valid       (res_valid),
        .res             (res)
    );

    // Output register: load when empty or being transferred
    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid             = out_valid_reg;
    assign shared_common         = out_reg.shared_common;
    assign union_common          = out_reg.union_common;
    assign weighted_shared       = out_reg.weighted_shared;
    assign weighted_union        = out_reg.weighted_union;
    assign targets_both          = out_reg.targets_both;
    assign targets_sharing       = out_reg.targets_sharing;
    assign mean_jaccard          = out_reg.mean_jaccard;
    assign mean_weighted_jaccard = out_reg.mean_weighted_jaccard;
    assign shared_all            = out_reg.shared_all;
    assign union_all             = out_reg.union_all;

endmodule
